[hw/rtl/idal_pkg.sv]
// Shared types and constants of the identifier allocator.
`default_nettype none

package idal_pkg;

    // Default number of identifiers handed out
    localparam int ID_COUNT_DEF = 256;

    // Width of the request and result identifier fields
    localparam int REQ_W = 8;

    // Command codes
    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_CLAIM   = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TAKEN     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } stat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC,
        S_FIN,
        S_SCAN
    } state_t;

    // Port strobes of the released-id ring
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ring_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/id_allocator_free_list.sv]
// Top level of the identifier allocator with an ordered list of released ids.
//
// Usage: a command transfer (command, req_id) is taken at a rising edge with start
// high and busy low. Exactly one result (ok, result_id, status) follows, shown for
// one cycle with done high; the receiver cannot stall it and must take it then.
// Steps after acceptance: allocate from the fresh counter, exhausted, out-of-range
//   ids, clear and unused codes finish in the execute state; allocate from the
//   released list, release and query wait on a memory read and finish in a final
//   state; claim walks the released-id ring, one entry per cycle through its single
//   read port, compacting the list as it goes, and finishes when the walk ends.
// One command is in work at a time; except after clear, busy drops as the result is
// shown, so the next command may be taken in that same cycle.
// Reset and clear: the allocated bitmap is a memory and is wiped by a sweep over
// all ID_COUNT entries, one entry per cycle, during which busy stays high. The clear
// result is shown at the start of its sweep.
`default_nettype none

module id_allocator_free_list
    import idal_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [2:0]       command,
    input  wire logic [REQ_W-1:0] req_id,
    output logic                  done,
    output logic                  ok,
    output logic      [REQ_W-1:0] result_id,
    output logic      [1:0]       status
);

    localparam int IDW = $clog2(ID_COUNT);
    localparam int CW  = $clog2(ID_COUNT + 1);
    localparam logic [CW-1:0]  CNT_MAX  = CW'(ID_COUNT);
    localparam logic [IDW-1:0] LAST_ID  = IDW'(ID_COUNT - 1);
    localparam logic [31:0]    ID_LIMIT = 32'(ID_COUNT);

    // Control registers
    state_t         state_reg, state_next;
    logic [IDW-1:0] head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  fresh_reg, fresh_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  w_reg, w_next;
    logic           pend_reg, pend_next;
    logic           found_reg, found_next;
    logic [IDW-1:0] sweep_reg, sweep_next;
    logic           done_reg, done_next;

    // Payload registers
    logic [2:0]       cmd_reg, cmd_next;
    logic [REQ_W-1:0] id_reg, id_next;
    logic             ok_reg, ok_next;
    logic [REQ_W-1:0] res_reg, res_next;
    stat_t            status_reg, status_next;

    // Allocated bitmap
    logic           map_mem [ID_COUNT];
    logic           map_rd_reg;
    logic           map_we;
    logic [IDW-1:0] map_wa;
    logic           map_wd;

    // Ring port signals
    ring_ctl_t      ring_ctl;
    logic [IDW-1:0] ring_rd_off;
    logic [IDW-1:0] ring_wr_off;
    logic [IDW-1:0] ring_wr_data;
    logic [IDW-1:0] ring_rd_data;

    // Decoded conditions
    logic [31:0]    id_wide;
    logic [IDW-1:0] id_idx;
    logic           in_range;
    logic           id_ge_fresh;
    logic           scan_end;
    cmd_t           cmd;

    assign id_wide     = {{(32-REQ_W){1'b0}}, id_reg};
    assign id_idx      = IDW'(id_reg);
    assign in_range    = id_wide < ID_LIMIT;
    assign id_ge_fresh = id_wide >= 32'(fresh_reg);
    assign scan_end    = (i_reg == count_reg) && !pend_reg;
    assign cmd         = cmd_t'(cmd_reg);

    idal_ring #(
        .ID_COUNT (ID_COUNT)
    ) u_ring (
        .clk     (clk),
        .head    (head_reg),
        .ctl     (ring_ctl),
        .rd_off  (ring_rd_off),
        .wr_off  (ring_wr_off),
        .wr_data (ring_wr_data),
        .rd_data (ring_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_reg == LAST_ID)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd)
                    CMD_ALLOC:   state_next = (count_reg != '0) ? S_FIN : S_IDLE;
                    CMD_CLAIM:   state_next = in_range ? S_SCAN : S_IDLE;
                    CMD_RELEASE: state_next = in_range ? S_FIN : S_IDLE;
                    CMD_QUERY:   state_next = in_range ? S_FIN : S_IDLE;
                    CMD_CLEAR:   state_next = S_SWEEP;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        i_next       = i_reg;
        w_next       = w_reg;
        pend_next    = 1'b0;
        found_next   = found_reg;
        sweep_next   = sweep_reg;
        done_next    = 1'b0;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        ok_next      = ok_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        map_we       = 1'b0;
        map_wa       = id_idx;
        map_wd       = 1'b0;
        ring_ctl     = '0;
        ring_rd_off  = '0;
        ring_wr_off  = '0;
        ring_wr_data = id_idx;

        unique case (state_reg)
            // Wipe one bitmap entry per cycle
            S_SWEEP:
            begin
                map_we     = 1'b1;
                map_wa     = sweep_reg;
                map_wd     = 1'b0;
                sweep_next = sweep_reg + IDW'(1);
            end

            // Latch the command transfer
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    id_next  = req_id;
                end
            end

            // First step of each command
            S_EXEC:
            begin
                res_next    = id_reg;
                ok_next     = 1'b0;
                status_next = ST_DONE;
                unique case (cmd)
                    CMD_ALLOC:
                    begin
                        if (count_reg != '0)
                        begin
                            ring_ctl.rd_en = 1'b1;
                        end
                        else if (fresh_reg != CNT_MAX)
                        begin
                            map_we     = 1'b1;
                            map_wa     = IDW'(fresh_reg);
                            map_wd     = 1'b1;
                            fresh_next = fresh_reg + CW'(1);
                            done_next  = 1'b1;
                            ok_next    = 1'b1;
                            res_next   = REQ_W'(fresh_reg);
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            res_next    = '0;
                            status_next = ST_EXHAUSTED;
                        end
                    end
                    CMD_CLAIM:
                    begin
                        i_next     = '0;
                        w_next     = '0;
                        found_next = 1'b0;
                        if (!in_range)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EXHAUSTED;
                        end
                    end
                    CMD_RELEASE, CMD_QUERY:
                    begin
                        if (!in_range)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_ALLOC;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        head_next  = '0;
                        count_next = '0;
                        fresh_next = '0;
                        sweep_next = '0;
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end

            // Finish commands that waited on a memory read
            S_FIN:
            begin
                done_next = 1'b1;
                unique case (cmd)
                    CMD_ALLOC:
                    begin
                        head_next  = (head_reg == LAST_ID) ? '0 : head_reg + IDW'(1);
                        count_next = count_reg - CW'(1);
                        map_we     = 1'b1;
                        map_wa     = ring_rd_data;
                        map_wd     = 1'b1;
                        ok_next    = 1'b1;
                        res_next   = REQ_W'(ring_rd_data);
                    end
                    CMD_RELEASE:
                    begin
                        if (map_rd_reg)
                        begin
                            map_we  = 1'b1;
                            map_wd  = 1'b0;
                            ok_next = 1'b1;
                            if (count_reg != CNT_MAX)
                            begin
                                ring_ctl.wr_en = 1'b1;
                                ring_wr_off    = IDW'(count_reg);
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            status_next = ST_NOT_ALLOC;
                        end
                    end
                    default:
                    begin
                        ok_next     = map_rd_reg;
                        status_next = map_rd_reg ? ST_DONE : ST_NOT_ALLOC;
                    end
                endcase
            end

            // Walk the ring, dropping the claimed id and compacting the rest
            S_SCAN:
            begin
                if (i_reg != count_reg)
                begin
                    ring_ctl.rd_en = 1'b1;
                    ring_rd_off    = IDW'(i_reg);
                    i_next         = i_reg + CW'(1);
                    pend_next      = 1'b1;
                end
                if (pend_reg)
                begin
                    if (ring_rd_data == id_idx)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        ring_ctl.wr_en = 1'b1;
                        ring_wr_off    = IDW'(w_reg);
                        ring_wr_data   = ring_rd_data;
                        w_next         = w_reg + CW'(1);
                    end
                end
                if (scan_end)
                begin
                    done_next = 1'b1;
                    if (found_reg || id_ge_fresh)
                    begin
                        count_next = w_reg;
                        if (id_ge_fresh)
                        begin
                            fresh_next = CW'(id_wide + 32'd1);
                        end
                        map_we  = 1'b1;
                        map_wd  = 1'b1;
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_TAKEN;
                    end
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            head_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            i_reg     <= i_next;
            w_reg     <= w_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        ok_reg     <= ok_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    // Bitmap memory, read at the latched id
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[id_idx];
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign result_id = res_reg;
    assign status    = status_reg;

    // Results never come in adjacent cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // The released list never grows beyond the id space
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("released list count beyond id space");

    // The fresh counter saturates at the id space
    a_fresh_max: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_MAX)
        else $error("fresh counter beyond id space");

    // Compaction never writes ahead of the read index
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (w_reg <= i_reg) && (i_reg <= count_reg))
        else $error("ring walk pointers out of order");

endmodule

`default_nettype wire

[hw/rtl/idal_ring.sv]
// Released-id ring: circular memory with head-relative read and write ports.
`default_nettype none

module idal_ring
    import idal_pkg::*;
#(
    parameter int ID_COUNT = ID_COUNT_DEF,
    localparam int IDW = $clog2(ID_COUNT)
)
(
    input  wire logic           clk,
    input  wire logic [IDW-1:0] head,
    input  wire ring_ctl_t      ctl,
    input  wire logic [IDW-1:0] rd_off,
    input  wire logic [IDW-1:0] wr_off,
    input  wire logic [IDW-1:0] wr_data,
    output logic      [IDW-1:0] rd_data
);

    localparam logic [IDW:0] DEPTH = (IDW+1)'(ID_COUNT);

    logic [IDW-1:0] mem [ID_COUNT];
    logic [IDW:0]   rd_sum;
    logic [IDW:0]   wr_sum;
    logic [IDW-1:0] rd_addr;
    logic [IDW-1:0] wr_addr;

    // Head plus offset, wrapped once around the ring
    always_comb
    begin
        rd_sum = {1'b0, head} + {1'b0, rd_off};
        wr_sum = {1'b0, head} + {1'b0, wr_off};
        rd_addr = (rd_sum >= DEPTH) ? IDW'(rd_sum - DEPTH) : IDW'(rd_sum);
        wr_addr = (wr_sum >= DEPTH) ? IDW'(wr_sum - DEPTH) : IDW'(wr_sum);
    end

    // Storage with registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[verif/tb_id_allocator_free_list.sv]
// Self-checking testbench of the identifier allocator with a released-id list.
`timescale 1ns / 100ps

module tb_id_allocator_free_list
    import idal_pkg::*;
();

    localparam int N_IDS        = ID_COUNT_DEF;
    localparam int RANDOM_ITEMS = 1025;
    localparam int CALM_TAIL    = 150;
    localparam int STALL_LIMIT  = 3000;

    // command codes the block leaves undecoded
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // weighting profiles of the random stretches
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    typedef struct {
        bit               ok;
        bit [REQ_W-1:0]   grant;
        stat_t            code;
    } outcome_t;

    // Tracks the allocator state and the outcomes still owed by the block
    class id_ledger;
        bit          owned [N_IDS];
        int unsigned freed_q [$];
        int unsigned fresh;
        outcome_t    awaited [$];
        int unsigned errors;

        function new();
            wipe();
            errors = 0;
        endfunction

        function void wipe();
            foreach (owned[i])
                owned[i] = 1'b0;
            freed_q.delete();
            fresh = 0;
        endfunction

        function bit is_freed(int unsigned id);
            foreach (freed_q[i])
                if (freed_q[i] == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function int unsigned pick_owned();
            int unsigned pool [$];
            foreach (owned[i])
                if (owned[i])
                    pool.insert(pool.size(), i);
            if (pool.size() == 0)
                return $urandom_range(0, N_IDS - 1);
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function int unsigned pick_freed();
            if (freed_q.size() == 0)
                return $urandom_range(0, N_IDS - 1);
            return freed_q[$urandom_range(0, freed_q.size() - 1)];
        endfunction

        // Apply an accepted command and queue the outcome it must produce
        function void note_command(logic [2:0] cmd, logic [REQ_W-1:0] rid);
            outcome_t    want;
            int unsigned id;
            int unsigned g;
            bit          in_range;
            int unsigned kept [$];
            id       = rid;
            in_range = id < N_IDS;
            want.ok    = 1'b0;
            want.grant = rid;
            want.code  = ST_DONE;
            case (cmd)
                CMD_ALLOC:
                begin
                    if (freed_q.size() > 0)
                    begin
                        g = freed_q[0];
                        freed_q.delete(0);
                        if (g < N_IDS)
                            owned[g] = 1'b1;
                        want.ok    = 1'b1;
                        want.grant = REQ_W'(g);
                    end
                    else if (fresh < N_IDS)
                    begin
                        g = fresh;
                        fresh++;
                        owned[g]   = 1'b1;
                        want.ok    = 1'b1;
                        want.grant = REQ_W'(g);
                    end
                    else
                    begin
                        want.grant = '0;
                        want.code  = ST_EXHAUSTED;
                    end
                end
                CMD_CLAIM:
                begin
                    if (!in_range)
                        want.code = ST_EXHAUSTED;
                    else if (is_freed(id) || id >= fresh)
                    begin
                        // drop the id from the list, keeping the order of the rest
                        foreach (freed_q[i])
                            if (freed_q[i] != id)
                                kept.insert(kept.size(), freed_q[i]);
                        freed_q = kept;
                        if (id >= fresh)
                            fresh = id + 1;
                        owned[id] = 1'b1;
                        want.ok   = 1'b1;
                    end
                    else
                        want.code = ST_TAKEN;
                end
                CMD_RELEASE:
                begin
                    if (in_range && owned[id])
                    begin
                        owned[id] = 1'b0;
                        if (freed_q.size() < N_IDS)
                            freed_q.insert(freed_q.size(), id);
                        want.ok = 1'b1;
                    end
                    else
                        want.code = ST_NOT_ALLOC;
                end
                CMD_QUERY:
                begin
                    if (in_range && owned[id])
                        want.ok = 1'b1;
                    else
                        want.code = ST_NOT_ALLOC;
                end
                CMD_CLEAR:
                begin
                    wipe();
                    want.ok = 1'b1;
                end
                default:
                    ;
            endcase
            awaited.insert(awaited.size(), want);
        endfunction

        // Compare one result transfer with the oldest outstanding outcome
        function void check_result(logic ok_v, logic [REQ_W-1:0] id_v, logic [1:0] st_v);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: ok %0d result_id %0d status %0d", ok_v, id_v, st_v);
                errors++;
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            if (ok_v !== want.ok)
            begin
                $error("ok mismatch: expected %0d, actual %0d", want.ok, ok_v);
                errors++;
            end
            if (id_v !== want.grant)
            begin
                $error("result_id mismatch: expected %0d, actual %0d", want.grant, id_v);
                errors++;
            end
            if (st_v !== want.code)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.code, st_v);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         command;
    logic [REQ_W-1:0]   req_id;
    logic               done;
    logic               ok;
    logic [REQ_W-1:0]   result_id;
    logic [1:0]         status;

    id_ledger    board;
    bit          pause_on;
    int unsigned quiet;

    id_allocator_free_list #(
        .ID_COUNT (N_IDS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .req_id    (req_id),
        .done      (done),
        .ok        (ok),
        .result_id (result_id),
        .status    (status)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: a strobed result is taken at the edge ending its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            board.check_result(ok, result_id, status);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one command and hold it until the transfer, then maybe pause
    task automatic issue(input logic [2:0] cmd, input logic [REQ_W-1:0] id);
        int unsigned gap;
        command <= cmd;
        req_id  <= id;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        board.note_command(cmd, id);
        if (pause_on && $urandom_range(0, 99) < 40)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One random command, weighted by the current stretch profile
    task automatic random_item(input int profile);
        int unsigned      cut [7];
        int unsigned      r;
        logic [REQ_W-1:0] rid;
        case (profile)
            MIX_GROW:   cut = '{60, 68, 72, 82, 92, 95, 98};
            MIX_SHRINK: cut = '{10, 14, 30, 75, 88, 93, 97};
            default:    cut = '{30, 42, 52, 72, 86, 92, 96};
        endcase
        r   = $urandom_range(0, 99);
        rid = REQ_W'($urandom_range(0, N_IDS - 1));
        if (r < cut[0])
            issue(CMD_ALLOC, rid);
        else if (r < cut[1])
        begin
            // claims at random or at or just above the fresh counter
            if ($urandom_range(0, 1))
                issue(CMD_CLAIM, rid);
            else
                issue(CMD_CLAIM, REQ_W'(board.fresh + $urandom_range(0, 3)));
        end
        else if (r < cut[2])
            issue(CMD_CLAIM, REQ_W'(board.pick_freed()));
        else if (r < cut[3])
            issue(CMD_RELEASE, REQ_W'(board.pick_owned()));
        else if (r < cut[4])
            issue(CMD_QUERY, $urandom_range(0, 1) ? REQ_W'(board.pick_owned()) : rid);
        else if (r < cut[5])
            issue(CMD_RELEASE, rid);
        else if (r < cut[6])
            issue(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), rid);
        else
            issue(CMD_CLEAR, rid);
    endtask

    // Stimulus
    initial
    begin
        int unsigned sent;
        int unsigned span;
        int          profile;
        bit          stretch_pause;
        int          c;

        board    = new();
        pause_on = 1'b0;
        quiet    = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = CMD_ALLOC;
        req_id   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty state, fresh grants, taken and skipped ids, exhaustion
        issue(CMD_QUERY, 8'd0);
        issue(CMD_RELEASE, 8'd0);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_ALLOC, 8'hFF);
        issue(CMD_CLAIM, 8'd1);
        issue(CMD_CLAIM, 8'd255);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_CLAIM, 8'd100);
        issue(CMD_QUERY, 8'd255);
        // released ids come back oldest first; a claim takes one out of the list
        issue(CMD_RELEASE, 8'd0);
        issue(CMD_RELEASE, 8'd255);
        issue(CMD_RELEASE, 8'd1);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_CLAIM, 8'd1);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_QUERY, 8'hAA);
        issue(CMD_RELEASE, 8'h55);
        // undecoded codes echo the id
        for (c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            issue(3'(c), 8'hA5);
        issue(CMD_CLEAR, 8'h5A);
        issue(CMD_ALLOC, 8'd0);
        issue(CMD_QUERY, 8'd0);

        // random stretches with varying mix and idling
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            profile       = $urandom_range(MIX_GROW, MIX_EVEN);
            span          = $urandom_range(30, 90);
            stretch_pause = $urandom_range(0, 2) != 0;
            pause_on      = stretch_pause && (sent + CALM_TAIL < RANDOM_ITEMS);
            if ($urandom_range(0, 5) == 0)
            begin
                issue(CMD_CLEAR, REQ_W'($urandom_range(0, N_IDS - 1)));
                sent++;
            end
            repeat (span)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    pause_on = stretch_pause && (sent + CALM_TAIL < RANDOM_ITEMS);
                    random_item(profile);
                    sent++;
                end
            end
        end
        start <= 1'b0;

        // drain, then watch for stray results
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (N_IDS + 8) @(posedge clk);

        if (board.errors == 0 && board.awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
